// File: hdl/tglos_pkg.sv
package tglos_pkg;

  // Field widths
  localparam int PIXEL_W = 16;
  localparam int IDX_W   = 12;
  localparam int COL_W   = 7;
  localparam int SIZE_W  = 9;
  localparam int REG_IDX_W = 2;

  // Default parameter values
  localparam int DEF_MAX_COLUMNS   = 64;
  localparam int DEF_MAX_ROWS      = 64;
  localparam int DEF_FRACTION_BITS = 10;

  // Line length carries LEN_BITS fraction bits
  localparam int LEN_BITS  = 14;
  localparam int SQ_W      = 2 * (PIXEL_W + 1 + LEN_BITS);
  localparam int SQ_STEPS  = SQ_W / 2;
  localparam int LEN_W     = SQ_W / 2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_COLUMNS     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROWS        = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TILE_WIDTH  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_TILE_HEIGHT = 2'd3;

  // Reset values
  localparam int RST_COLUMNS = 64;
  localparam int RST_ROWS    = 64;
  localparam logic [SIZE_W-1:0] RST_TILE_SIZE = 9'd32;

  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_QUERY,
    OP_SKIP
  } op_t;

  typedef struct packed {
    logic [COL_W-1:0]  columns;
    logic [COL_W-1:0]  rows;
    logic [SIZE_W-1:0] tile_w;
    logic [SIZE_W-1:0] tile_h;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   tile_index;
    logic               tile_passable;
    logic [PIXEL_W-1:0] start_x;
    logic [PIXEL_W-1:0] start_y;
    logic [PIXEL_W-1:0] end_x;
    logic [PIXEL_W-1:0] end_y;
  } q_item_t;

endpackage

// File: hdl/tglos_in_if.sv
interface tglos_in_if;
  import tglos_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [IDX_W-1:0]   tile_index;
  logic               tile_passable;
  logic [PIXEL_W-1:0] start_x;
  logic [PIXEL_W-1:0] start_y;
  logic [PIXEL_W-1:0] end_x;
  logic [PIXEL_W-1:0] end_y;

  modport source(output valid, action, tile_index, tile_passable,
                 start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, action, tile_index, tile_passable,
               start_x, start_y, end_x, end_y, output ready);
endinterface

// File: hdl/tglos_out_if.sv
interface tglos_out_if;
  logic valid;
  logic ready;
  logic blocked;

  modport source(output valid, blocked, input ready);
  modport sink(input valid, blocked, output ready);
endinterface

// File: hdl/tile_grid_line_of_sight_unit.sv
// Write word: leaves the queue, no result.
// Query: 4 tile divides, a square root and two step divides (skipped when start equals
// end), then one map check per marched position (up to MAX_COLUMNS+MAX_ROWS+2);
// the divider and the root are serial.
// A 2-word input queue keeps accepting until full while a query runs or a result waits.
// Synchronous reset restores the default grid and tile size; the map is not cleared.
module tile_grid_line_of_sight_unit import tglos_pkg::*; #(
  parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS      = DEF_MAX_ROWS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [SIZE_W-1:0]    wr_data,
  tglos_in_if.sink             in_ch,
  tglos_out_if.source          out_ch
);

  localparam int RST_COLS_EFF = (RST_COLUMNS > MAX_COLUMNS) ? MAX_COLUMNS : RST_COLUMNS;
  localparam int RST_ROWS_EFF = (RST_ROWS > MAX_ROWS) ? MAX_ROWS : RST_ROWS;

  cfg_t             cfg;
  q_item_t          q_item;
  logic             q_valid;
  logic             q_pop;
  logic [COL_W-1:0] wr_cols, wr_rows;
  logic [SIZE_W-1:0] wr_size;

  // clamp grid size, a zero tile size counts as one
  assign wr_cols = (32'(wr_data[COL_W-1:0]) > MAX_COLUMNS) ? COL_W'(MAX_COLUMNS)
                                                            : wr_data[COL_W-1:0];
  assign wr_rows = (32'(wr_data[COL_W-1:0]) > MAX_ROWS) ? COL_W'(MAX_ROWS)
                                                         : wr_data[COL_W-1:0];
  assign wr_size = (wr_data == '0) ? SIZE_W'(1) : wr_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns <= COL_W'(RST_COLS_EFF);
      cfg.rows    <= COL_W'(RST_ROWS_EFF);
      cfg.tile_w  <= RST_TILE_SIZE;
      cfg.tile_h  <= RST_TILE_SIZE;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_COLUMNS:     cfg.columns <= wr_cols;
        REG_ROWS:        cfg.rows    <= wr_rows;
        REG_TILE_WIDTH:  cfg.tile_w  <= wr_size;
        REG_TILE_HEIGHT: cfg.tile_h  <= wr_size;
      endcase
    end
  end

  tglos_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  tglos_back #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_ROWS      (MAX_ROWS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: hdl/tglos_front.sv
module tglos_front import tglos_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  tglos_in_if.sink   in_ch,
  output q_item_t    q_item,
  output logic       q_valid,
  input  logic       q_pop
);

  localparam int MAP_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam logic [1:0] QDEPTH = 2'd2;

  q_item_t    slots [2];
  q_item_t    entry;
  logic [1:0] count;
  logic       wp;
  logic       rp;
  logic       push;

  assign in_ch.ready = (count != QDEPTH);
  assign push        = in_ch.valid & in_ch.ready;
  assign q_valid     = (count != 2'd0);
  assign q_item      = slots[rp];

  // classify the incoming word
  always_comb begin
    entry.tile_index    = in_ch.tile_index;
    entry.tile_passable = in_ch.tile_passable;
    entry.start_x       = in_ch.start_x;
    entry.start_y       = in_ch.start_y;
    entry.end_x         = in_ch.end_x;
    entry.end_y         = in_ch.end_y;
    priority if (in_ch.action == ACT_QUERY) begin
      entry.op = OP_QUERY;
    end else if (32'(in_ch.tile_index) < MAP_DEPTH) begin
      entry.op = OP_WRITE;
    end else begin
      entry.op = OP_SKIP;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= entry;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= QDEPTH)
    else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (count == QDEPTH && !q_pop) |=> (count == QDEPTH))
    else $error("full queue lost an entry");

endmodule

// File: hdl/tglos_back.sv
module tglos_back import tglos_pkg::*; #(
  parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS      = DEF_MAX_ROWS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  q_item_t     q_item,
  input  logic        q_valid,
  output logic        q_pop,
  tglos_out_if.source out_ch
);

  localparam int F         = FRACTION_BITS;
  localparam int PW        = F + PIXEL_W + 2;
  localparam int DVW       = F + LEN_W + 1;
  localparam int SW        = F + 4;
  localparam int DW        = F + 1;
  localparam int MAP_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int XW        = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int YW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int LIMIT     = MAX_COLUMNS + MAX_ROWS + 2;
  localparam int NW        = $clog2(LIMIT + 1);
  localparam int DCW       = $clog2(DVW + 1);
  localparam int SCW       = $clog2(SQ_STEPS + 1);
  localparam logic [PW:0]      TWO      = (PW + 1)'(2) << F;
  localparam logic [2*F+4:0]   NEAR_LIM = (2 * F + 5)'(9) << (2 * F);
  localparam logic [SQ_W-1:0]  SQ_TOP   = SQ_W'(1) << (SQ_W - 2);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_DIV, ST_STORE, ST_SQUARE, ST_SUM, ST_SQRT,
    ST_CHECK, ST_MUL, ST_ADDR, ST_EVAL, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    JOB_AX, JOB_AY, JOB_EX, JOB_EY, JOB_SX, JOB_SY
  } job_t;

  state_t state;
  job_t   job;

  logic [PIXEL_W-1:0] pix_sx, pix_sy, pix_ex, pix_ey;
  logic [PIXEL_W-1:0] dxm, dym;
  logic               dxn, dyn;
  logic [2*PIXEL_W-1:0] dx2, dy2;
  logic signed [PW-1:0] ax, ay, ex, ey;
  logic signed [SW-1:0] stx, sty;

  // shared divider
  logic [DVW-1:0]   div_num, div_q;
  logic [LEN_W-1:0] div_rem, div_den;
  logic [DCW-1:0]   div_cnt;
  logic [LEN_W:0]   div_trial, div_diff;
  logic             div_ge;
  logic signed [SW-1:0] q_step;

  // square root
  logic [SQ_W-1:0] sqv, sqr, sqb, sq_sum;
  logic [SCW-1:0]  sq_cnt;
  logic            sq_ge;
  logic [2*PIXEL_W:0] s2;

  // march
  logic [NW-1:0]        cnt;
  logic [XW-1:0]        ix;
  logic [YW-1:0]        iy;
  logic [DW-1:0]        ddx, ddy;
  logic                 far;
  logic [YW+COL_W-1:0]  row_off;
  logic [2*DW-1:0]      nxsq, nysq;
  logic                 near;
  logic                 mem_q;
  logic                 result;
  logic [AW-1:0]        rd_addr;
  logic signed [PW-1:0] xlim, ylim;
  logic signed [PW:0]   diff_x, diff_y, abs_x, abs_y;
  logic [2*DW:0]        d2;
  logic [PIXEL_W:0]     dx_s, dy_s;

  logic mem [MAP_DEPTH];

  assign q_pop = (state == ST_IDLE) && q_valid;

  // divider step
  assign div_trial = {div_rem, div_num[DVW-1]};
  assign div_diff  = div_trial - {1'b0, div_den};
  assign div_ge    = !div_diff[LEN_W];
  assign q_step    = {1'b0, div_q[SW-2:0]};

  // root step
  assign sq_sum = sqr + sqb;
  assign sq_ge  = (sqv >= sq_sum);
  assign s2     = {1'b0, dx2} + {1'b0, dy2};

  // query differences in pixels
  assign dx_s = {1'b0, q_item.end_x} - {1'b0, q_item.start_x};
  assign dy_s = {1'b0, q_item.end_y} - {1'b0, q_item.start_y};

  // grid bounds and distance to end
  assign xlim   = $signed({{(PW - COL_W - F){1'b0}}, cfg.columns, {F{1'b0}}});
  assign ylim   = $signed({{(PW - COL_W - F){1'b0}}, cfg.rows, {F{1'b0}}});
  assign diff_x = {ax[PW-1], ax} - {ex[PW-1], ex};
  assign diff_y = {ay[PW-1], ay} - {ey[PW-1], ey};
  assign abs_x  = diff_x[PW] ? -diff_x : diff_x;
  assign abs_y  = diff_y[PW] ? -diff_y : diff_y;
  assign d2      = {1'b0, nxsq} + {1'b0, nysq};
  assign rd_addr = AW'(ix) + AW'(row_off);

  // passability map
  always_ff @(posedge clk) begin
    if (q_pop && q_item.op == OP_WRITE) begin
      mem[AW'(q_item.tile_index)] <= q_item.tile_passable;
    end
    if (state == ST_ADDR) begin
      mem_q <= mem[rd_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      job           <= JOB_AX;
      out_ch.valid  <= 1'b0;
      out_ch.blocked <= 1'b0;
    end else begin
      // result taken; ST_DONE decides the flag itself
      if (out_ch.valid && out_ch.ready && state != ST_DONE) out_ch.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid && q_item.op == OP_QUERY) begin
            pix_sx <= q_item.start_x;
            pix_sy <= q_item.start_y;
            pix_ex <= q_item.end_x;
            pix_ey <= q_item.end_y;
            dxn    <= dx_s[PIXEL_W];
            dyn    <= dy_s[PIXEL_W];
            dxm    <= dx_s[PIXEL_W] ? PIXEL_W'(-dx_s) : dx_s[PIXEL_W-1:0];
            dym    <= dy_s[PIXEL_W] ? PIXEL_W'(-dy_s) : dy_s[PIXEL_W-1:0];
            job    <= JOB_AX;
            state  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          div_rem <= '0;
          div_q   <= '0;
          unique case (job)
            JOB_AX: begin
              div_num <= {pix_sx, {(DVW - PIXEL_W){1'b0}}};
              div_den <= LEN_W'(cfg.tile_w);
              div_cnt <= DCW'(PIXEL_W + F);
            end
            JOB_AY: begin
              div_num <= {pix_sy, {(DVW - PIXEL_W){1'b0}}};
              div_den <= LEN_W'(cfg.tile_h);
              div_cnt <= DCW'(PIXEL_W + F);
            end
            JOB_EX: begin
              div_num <= {pix_ex, {(DVW - PIXEL_W){1'b0}}};
              div_den <= LEN_W'(cfg.tile_w);
              div_cnt <= DCW'(PIXEL_W + F);
            end
            JOB_EY: begin
              div_num <= {pix_ey, {(DVW - PIXEL_W){1'b0}}};
              div_den <= LEN_W'(cfg.tile_h);
              div_cnt <= DCW'(PIXEL_W + F);
            end
            JOB_SX: begin
              div_num <= DVW'({dxm, {(F + LEN_BITS + 1){1'b0}}})
                         + DVW'(sqr[LEN_W-1:1]);
              div_den <= sqr[LEN_W-1:0];
              div_cnt <= DCW'(DVW);
            end
            default: begin
              div_num <= DVW'({dym, {(F + LEN_BITS + 1){1'b0}}})
                         + DVW'(sqr[LEN_W-1:1]);
              div_den <= sqr[LEN_W-1:0];
              div_cnt <= DCW'(DVW);
            end
          endcase
          state <= ST_DIV;
        end
        ST_DIV: begin
          div_rem <= div_ge ? div_diff[LEN_W-1:0] : div_trial[LEN_W-1:0];
          div_q   <= {div_q[DVW-2:0], div_ge};
          div_num <= {div_num[DVW-2:0], 1'b0};
          div_cnt <= div_cnt - DCW'(1);
          if (div_cnt == DCW'(1)) state <= ST_STORE;
        end
        ST_STORE: begin
          unique case (job)
            JOB_AX: begin ax <= $signed(div_q[PW-1:0]); job <= JOB_AY; state <= ST_LOAD; end
            JOB_AY: begin ay <= $signed(div_q[PW-1:0]); job <= JOB_EX; state <= ST_LOAD; end
            JOB_EX: begin ex <= $signed(div_q[PW-1:0]); job <= JOB_EY; state <= ST_LOAD; end
            JOB_EY: begin ey <= $signed(div_q[PW-1:0]); state <= ST_SQUARE; end
            JOB_SX: begin
              stx   <= dxn ? -q_step : q_step;
              job   <= JOB_SY;
              state <= ST_LOAD;
            end
            default: begin
              sty   <= dyn ? -q_step : q_step;
              cnt   <= '0;
              state <= ST_CHECK;
            end
          endcase
        end
        ST_SQUARE: begin
          dx2   <= dxm * dxm;
          dy2   <= dym * dym;
          state <= ST_SUM;
        end
        ST_SUM: begin
          if (s2 == '0) begin
            stx   <= '0;
            sty   <= '0;
            cnt   <= '0;
            state <= ST_CHECK;
          end else begin
            sqv    <= SQ_W'({s2, {(2 * LEN_BITS){1'b0}}});
            sqr    <= '0;
            sqb    <= SQ_TOP;
            sq_cnt <= SCW'(SQ_STEPS);
            state  <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_ge) begin
            sqv <= sqv - sq_sum;
            sqr <= (sqr >> 1) + sqb;
          end else begin
            sqr <= sqr >> 1;
          end
          sqb    <= sqb >> 2;
          sq_cnt <= sq_cnt - SCW'(1);
          if (sq_cnt == SCW'(1)) begin
            job   <= JOB_SX;
            state <= ST_LOAD;
          end
        end
        ST_CHECK: begin
          priority if (cnt == NW'(LIMIT)) begin
            result <= 1'b0;
            state  <= ST_DONE;
          end else if (ax < 0 || ay < 0 || ax >= xlim || ay >= ylim) begin
            result <= 1'b0;
            state  <= ST_DONE;
          end else begin
            ix    <= ax[F +: XW];
            iy    <= ay[F +: YW];
            ddx   <= abs_x[DW-1:0];
            ddy   <= abs_y[DW-1:0];
            far   <= (abs_x >= $signed(TWO)) || (abs_y >= $signed(TWO));
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          row_off <= iy * cfg.columns;
          nxsq    <= ddx * ddx;
          nysq    <= ddy * ddy;
          state   <= ST_ADDR;
        end
        ST_ADDR: begin
          near  <= !far && ({d2, 2'b00} < {1'b0, NEAR_LIM});
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          priority if (!mem_q) begin
            result <= 1'b1;
            state  <= ST_DONE;
          end else if (near) begin
            result <= 1'b0;
            state  <= ST_DONE;
          end else begin
            ax    <= ax + {{(PW - SW){stx[SW-1]}}, stx};
            ay    <= ay + {{(PW - SW){sty[SW-1]}}, sty};
            cnt   <= cnt + NW'(1);
            state <= ST_CHECK;
          end
        end
        ST_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid   <= 1'b1;
            out_ch.blocked <= result;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_rem < div_den))
    else $error("divider remainder out of range");
  a_march_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> (cnt <= NW'(LIMIT)))
    else $error("march count past limit");
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADDR) |-> (32'(rd_addr) < MAP_DEPTH))
    else $error("map read out of range");
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> ($past(state) == ST_DONE))
    else $error("result without finished query");

endmodule
